### rtl/core/zlhch_pkg.sv
// shared types, constants and hash step for the zip local header check block
package zlhch_pkg;

   // defaults for top-level parameters
   localparam int BUFFER_BYTES_DEFAULT = 512;
   localparam int QUEUE_DEPTH_DEFAULT  = 4;

   // fixed widths of the beat fields
   localparam int LEN_W    = 10;
   localparam int STATUS_W = 4;
   localparam int HASH_W   = 64;

   // header layout, byte offsets from the start of the image
   localparam int MAGIC_POS     = 0;
   localparam int METHOD_POS    = 8;
   localparam int SIZE_POS      = 18;
   localparam int NAME_LEN_POS  = 26;
   localparam int EXTRA_LEN_POS = 28;
   localparam int HEADER_BYTES  = 30;

   localparam logic [31:0]       ZIP_MAGIC      = 32'h04034b50;
   localparam logic [HASH_W-1:0] FNV_BASIS      = 64'hcbf29ce484222325;
   localparam logic [LEN_W-1:0]  MIN_SIZE_RESET = 10'd10;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 4'd0;
   localparam logic [STATUS_W-1:0] STATUS_OVERRUN    = 4'd1;
   localparam logic [STATUS_W-1:0] STATUS_SHORT      = 4'd2;
   localparam logic [STATUS_W-1:0] STATUS_MAGIC      = 4'd3;
   localparam logic [STATUS_W-1:0] STATUS_COMPRESSED = 4'd4;
   localparam logic [STATUS_W-1:0] STATUS_EXTRA      = 4'd5;
   localparam logic [STATUS_W-1:0] STATUS_NAME_LONG  = 4'd6;
   localparam logic [STATUS_W-1:0] STATUS_DATA_LONG  = 4'd7;
   localparam logic [STATUS_W-1:0] STATUS_SMALL      = 4'd8;

   // one classified byte handed from front to back
   typedef struct packed {
      logic [7:0]          data_byte;
      logic                hash_en;
      logic                last;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    name_length;
      logic [LEN_W-1:0]    data_size;
      logic [LEN_W-1:0]    data_offset;
   } zlhch_entry_type;

   // fnv-1a 64 step; prime is 2^40 + 0x1b3, done as shifts and adds
   function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

### rtl/core/zip_local_header_check_hash.sv
// Checks the local file header of a stored zip image streamed in one byte per
// beat and hashes its payload with fnv-1a 64. The image ends on the beat with
// req_last_byte set; that beat yields one result with a status code and, when
// the status is ok, the name length, payload size, payload offset and hash
// (all other fields zero). Bytes beyond BUFFER_BYTES are dropped and flag an
// overrun. One byte is taken every cycle while the queue has room; when it is
// full, req_ready drops. The result passes from the queue to the result
// register after the final byte is taken. A queue of QUEUE_DEPTH beats lets
// the input keep flowing while a result waits to be taken. min_data_size is
// written through csr_write_enable and csr_write_data and resets to 10; the
// user must write it only while the block is idle, which is not enforced.
module zip_local_header_check_hash import zlhch_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [LEN_W-1:0]    rsp_name_length,
   output logic [LEN_W-1:0]    rsp_data_size,
   output logic [LEN_W-1:0]    rsp_data_offset,
   output logic [HASH_W-1:0]   rsp_payload_hash,
   input  logic                csr_write_enable,
   input  logic [LEN_W-1:0]    csr_write_data
);

   logic            push_valid, push_ready;
   logic            pop_valid, pop_ready;
   zlhch_entry_type push_entry, pop_entry;

   // header parse and checks
   zlhch_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   // decoupling queue
   zlhch_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // hash and result
   zlhch_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_entry        (pop_entry),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_name_length  (rsp_name_length),
      .rsp_data_size    (rsp_data_size),
      .rsp_data_offset  (rsp_data_offset),
      .rsp_payload_hash (rsp_payload_hash)
   );

endmodule

### rtl/core/zlhch_front.sv
// front end: byte position, header capture, payload window and final checks
module zlhch_front import zlhch_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   input  logic                  csr_write_enable,
   input  logic [LEN_W-1:0]      csr_write_data,
   output logic                  push_valid,
   input  logic                  push_ready,
   output zlhch_entry_type       push_entry
);

   localparam int PW = $clog2(BUFFER_BYTES + 1);
   localparam int XW = 34;

   logic [LEN_W-1:0] min_size_ff;
   logic [PW-1:0]    pos_ff, pos_in;
   logic             overrun_ff, overrun_in;
   logic [31:0]      magic_ff, magic_in;
   logic [15:0]      method_ff, method_in;
   logic [31:0]      packed_ff, packed_in;
   logic [15:0]      name_len_ff, name_len_in;
   logic [15:0]      extra_len_ff, extra_len_in;

   logic             accept;
   logic             overrun_now;
   logic [XW-1:0]    pos_x, len_x, start_x, name_end_x, data_end_x;
   logic [STATUS_W-1:0] status;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid & push_ready;

   // a byte past the buffer is dropped
   assign overrun_now = (pos_ff >= PW'(BUFFER_BYTES));

   // header field capture at fixed positions
   always_comb begin
      magic_in     = magic_ff;
      method_in    = method_ff;
      packed_in    = packed_ff;
      name_len_in  = name_len_ff;
      extra_len_in = extra_len_ff;
      for (int k = 0; k < 4; k++) begin
         if (pos_ff == PW'(MAGIC_POS + k)) magic_in[8*k +: 8] = req_data_byte;
         if (pos_ff == PW'(SIZE_POS + k)) packed_in[8*k +: 8] = req_data_byte;
      end
      for (int k = 0; k < 2; k++) begin
         if (pos_ff == PW'(METHOD_POS + k)) method_in[8*k +: 8] = req_data_byte;
         if (pos_ff == PW'(NAME_LEN_POS + k)) name_len_in[8*k +: 8] = req_data_byte;
         if (pos_ff == PW'(EXTRA_LEN_POS + k)) extra_len_in[8*k +: 8] = req_data_byte;
      end
   end

   // payload window from the completed header
   assign pos_x   = XW'(pos_ff);
   assign len_x   = pos_x + XW'(1);
   assign start_x = XW'(HEADER_BYTES) + XW'(name_len_ff);

   // end of name and end of payload with this beat's fields
   assign name_end_x = XW'(HEADER_BYTES) + XW'(name_len_in);
   assign data_end_x = name_end_x + XW'(packed_in);

   // checks in priority order
   always_comb begin
      if (overrun_ff || overrun_now) begin
         status = STATUS_OVERRUN;
      end else if (len_x < XW'(HEADER_BYTES)) begin
         status = STATUS_SHORT;
      end else if (magic_in != ZIP_MAGIC) begin
         status = STATUS_MAGIC;
      end else if (method_in != 16'd0) begin
         status = STATUS_COMPRESSED;
      end else if (extra_len_in != 16'd0 || name_len_in[15]) begin
         status = STATUS_EXTRA;
      end else if (name_end_x > len_x) begin
         status = STATUS_NAME_LONG;
      end else if (data_end_x > len_x) begin
         status = STATUS_DATA_LONG;
      end else if (packed_in < {22'd0, min_size_ff}) begin
         status = STATUS_SMALL;
      end else begin
         status = STATUS_OK;
      end
   end

   // classified beat toward the back end
   always_comb begin
      push_entry.data_byte   = req_data_byte;
      push_entry.hash_en     = !overrun_now && (pos_x >= start_x) &&
                               ((pos_x - start_x) < XW'(packed_ff));
      push_entry.last        = req_last_byte;
      push_entry.status      = status;
      push_entry.name_length = name_len_in[LEN_W-1:0];
      push_entry.data_size   = packed_in[LEN_W-1:0];
      push_entry.data_offset = name_end_x[LEN_W-1:0];
   end

   // position advance, restart after the final byte
   always_comb begin
      pos_in     = overrun_now ? pos_ff : pos_ff + PW'(1);
      overrun_in = overrun_ff | overrun_now;
   end

   // image state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         overrun_ff   <= 1'b0;
         magic_ff     <= '0;
         method_ff    <= '0;
         packed_ff    <= '0;
         name_len_ff  <= '0;
         extra_len_ff <= '0;
      end else if (accept) begin
         if (req_last_byte) begin
            pos_ff       <= '0;
            overrun_ff   <= 1'b0;
            magic_ff     <= '0;
            method_ff    <= '0;
            packed_ff    <= '0;
            name_len_ff  <= '0;
            extra_len_ff <= '0;
         end else begin
            pos_ff       <= pos_in;
            overrun_ff   <= overrun_in;
            magic_ff     <= magic_in;
            method_ff    <= method_in;
            packed_ff    <= packed_in;
            name_len_ff  <= name_len_in;
            extra_len_ff <= extra_len_in;
         end
      end
   end

   // minimum payload size register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_size_ff <= MIN_SIZE_RESET;
      end else if (csr_write_enable) begin
         min_size_ff <= csr_write_data;
      end
   end

endmodule

### rtl/core/zlhch_queue.sv
// short fifo of classified beats between front and back
module zlhch_queue import zlhch_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  zlhch_entry_type push_entry,
   output logic            pop_valid,
   input  logic            pop_ready,
   output zlhch_entry_type pop_entry
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   zlhch_entry_type slot_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      if (!do_push && do_pop) count_in = count_ff - CW'(1);
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/zlhch_back.sv
// back end: fnv-1a 64 over payload beats and the result register
module zlhch_back import zlhch_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  zlhch_entry_type     pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [LEN_W-1:0]    rsp_name_length,
   output logic [LEN_W-1:0]    rsp_data_size,
   output logic [LEN_W-1:0]    rsp_data_offset,
   output logic [HASH_W-1:0]   rsp_payload_hash
);

   logic [HASH_W-1:0]   hash_ff, hash_in;
   logic                valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [LEN_W-1:0]    name_len_ff, size_ff, offset_ff;
   logic [HASH_W-1:0]   result_hash_ff;
   logic                do_pop, ok;

   // a final beat waits until the result register is free
   assign pop_ready = !pop_entry.last || !valid_ff || rsp_ready;
   assign do_pop    = pop_valid & pop_ready;
   assign ok        = (pop_entry.status == STATUS_OK);

   // hash step for payload beats
   assign hash_in = pop_entry.hash_en ? fnv_step(hash_ff, pop_entry.data_byte) : hash_ff;

   // running hash
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_BASIS;
      end else if (do_pop) begin
         hash_ff <= pop_entry.last ? FNV_BASIS : hash_in;
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (do_pop && pop_entry.last) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   // result fields; lengths, offset and hash zeroed unless the image checks out
   always_ff @(posedge clock) begin
      if (do_pop && pop_entry.last) begin
         status_ff      <= pop_entry.status;
         name_len_ff    <= ok ? pop_entry.name_length : '0;
         size_ff        <= ok ? pop_entry.data_size : '0;
         offset_ff      <= ok ? pop_entry.data_offset : '0;
         result_hash_ff <= ok ? hash_in : '0;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_name_length  = name_len_ff;
   assign rsp_data_size    = size_ff;
   assign rsp_data_offset  = offset_ff;
   assign rsp_payload_hash = result_hash_ff;

endmodule
